[rtl/boid_pkg.sv]
// boid_pkg: item structs, register indexes, function codes and state encoding
// for the boid flocking update block. no dependencies.
`timescale 1ns / 1ps

package boid_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RANGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COH_GAIN     = 3'd6;

    localparam logic [1:0] FN_LOAD     = 2'd0;
    localparam logic [1:0] FN_NEIGHBOR = 2'd1;
    localparam logic [1:0] FN_MOVE     = 2'd2;

    // shared divider: numerator and divisor widths
    localparam int DIV_NW = 38;
    localparam int DIV_DW = 25;
    // shared square root: operand and root widths (operand width even)
    localparam int SQ_W  = 50;
    localparam int SQ_RW = 25;
    // component width after range reduction
    localparam int MAG_W = 24;
    localparam int UNIT_SHIFT = 14;

    typedef struct packed {
        logic [1:0]         func;
        logic [19:0]        pos_x;
        logic [19:0]        pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [19:0]        new_x;
        logic [19:0]        new_y;
        logic signed [15:0] new_vx;
        logic signed [15:0] new_vy;
        logic [8:0]         seen_count;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NB_DX,
        ST_NB_DY,
        ST_NB_LIM,
        ST_NB_ACC,
        ST_STEER,
        ST_CO_X,
        ST_CO_Y,
        ST_CO_SET,
        ST_UV_ABS,
        ST_UV_SHIFT,
        ST_UV_SQA,
        ST_UV_SQB,
        ST_UV_SQC,
        ST_UV_ROOT,
        ST_UV_DIVA,
        ST_UV_DIVB,
        ST_UV_END,
        ST_WT_MUL,
        ST_WT_ADD,
        ST_SC_X,
        ST_SC_Y,
        ST_SC_SET,
        ST_MV_X,
        ST_MV_Y,
        ST_OUT
    } t_state;

endpackage

[rtl/boid_flocking_update.sv]
// boid_flocking_update: top level, sequencer around one shared multiplier,
// a shared divider (boid_div) and a square root unit (boid_sqrt); uses boid_pkg
//
// channel  direction  handshake               payload
// in       input      i_in_valid/o_in_ready   i_in_item (t_in_item)
// out      output     o_out_valid/i_out_ready o_out_item (t_out_item)
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// load and ignored requests are handled in the idle state; a neighbor makes three
// multiplies through the shared multiplier. a last neighbor adds the steering
// update: four unit vectors, each up to a square root and two divisions, plus
// gains and speed. a move takes two modulo divisions. synchronous reset, no
// clearing pass.
// a result waits in the output register; the block stalls only when a second
// result is ready before the first has been taken.
`timescale 1ns / 1ps

module boid_flocking_update #(
    parameter int MAX_NEIGHBORS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  boid_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output boid_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [boid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [boid_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import boid_pkg::*;

    localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int SVW = CW + 16;
    localparam int SPW = CW + 20;
    localparam int SOW = CW + 21;
    localparam int VW  = (CW + 22 > 34) ? CW + 22 : 34;

    // configuration
    logic [11:0]        r_width, r_height, r_view;
    logic [14:0]        r_target;
    logic signed [15:0] r_gs, r_ga, r_gc;

    // own boid and neighbor sums
    logic [19:0]          r_self_x, r_self_y;
    logic signed [15:0]   r_self_vx, r_self_vy;
    logic signed [SVW-1:0] r_sum_vel_x, r_sum_vel_y;
    logic [SPW-1:0]       r_sum_pos_x, r_sum_pos_y;
    logic signed [SOW-1:0] r_sum_off_x, r_sum_off_y;
    logic [CW-1:0]        r_cnt;

    t_state r_state, n_state;

    // working registers
    logic [19:0]          r_px, r_py;
    logic signed [15:0]   r_nvx, r_nvy;
    logic                 r_last;
    logic signed [20:0]   r_dx, r_dy;
    logic signed [49:0]   r_prod;
    logic [SQ_W-1:0]      r_acc;
    logic signed [VW-1:0] r_va, r_vb;
    logic [VW-1:0]        r_ma, r_mb;
    logic                 r_na, r_nb;
    logic [SQ_RW-1:0]     r_len;
    logic signed [15:0]   r_ua, r_ub;
    logic signed [15:0]   r_ax, r_ay, r_cx, r_cy, r_sx, r_sy;
    logic [1:0]           r_vec;
    logic [2:0]           r_k;
    logic                 r_sub;
    logic                 r_clr;
    logic                 r_out_valid;
    t_out_item            r_out;

    // shared unit controls
    logic signed [24:0]   m_a, m_b;
    logic signed [49:0]   m_p;
    logic                 div_start, div_done;
    logic [DIV_NW-1:0]    div_num, div_quot;
    logic [DIV_DW-1:0]    div_den, div_rem;
    logic                 sq_start, sq_done;
    logic [SQ_RW-1:0]     sq_root;

    logic                 in_acc;
    logic                 out_free;
    logic                 hit;
    logic [14:0]          abs_ua, abs_ub;
    logic [15:0]          q16;
    logic [29:0]          rnd;

    // move path
    logic [19:0]          mv_pos;
    logic signed [15:0]   mv_vel;
    logic [11:0]          mv_size;
    logic signed [21:0]   mv_v;
    logic [21:0]          mv_mag;
    logic [20:0]          mv_span;
    logic [20:0]          mv_rem;
    logic [20:0]          mv_fold;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign m_p = m_a * m_b;

    assign hit = (r_acc != '0) && (r_acc < SQ_W'({r_prod, 16'b0}))
              && (r_cnt < CW'(MAX_NEIGHBORS));

    assign abs_ua = 15'(r_ua < 0 ? -r_ua : r_ua);
    assign abs_ub = 15'(r_ub < 0 ? -r_ub : r_ub);
    assign q16    = div_quot[15:0];
    assign rnd    = 30'(r_prod) + 30'd8192;

    always_comb begin
        if (r_state == ST_MV_Y) begin
            mv_pos  = r_self_y;
            mv_vel  = r_self_vy;
            mv_size = r_height;
        end else begin
            mv_pos  = r_self_x;
            mv_vel  = r_self_vx;
            mv_size = r_width;
        end
        mv_v    = $signed({2'b00, mv_pos}) + 22'(mv_vel);
        mv_mag  = mv_v[21] ? 22'(-mv_v) : 22'(mv_v);
        mv_span = (mv_size == '0) ? 21'h100000 : {1'b0, mv_size, 8'b0};
        mv_rem  = div_rem[20:0];
        mv_fold = (mv_v[21] && mv_rem != '0) ? mv_span - mv_rem : mv_rem;
    end

    boid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    boid_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_op    (r_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        m_a       = '0;
        m_b       = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.func)
                        FN_NEIGHBOR: n_state = ST_NB_DX;
                        FN_MOVE:     n_state = ST_MV_X;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_NB_DX: begin
                m_a = 25'(r_dx);
                m_b = 25'(r_dx);
                n_state = ST_NB_DY;
            end
            ST_NB_DY: begin
                m_a = 25'(r_dy);
                m_b = 25'(r_dy);
                n_state = ST_NB_LIM;
            end
            ST_NB_LIM: begin
                m_a = $signed(25'(r_view));
                m_b = $signed(25'(r_view));
                n_state = ST_NB_ACC;
            end
            ST_NB_ACC: begin
                n_state = r_last ? ST_STEER : ST_IDLE;
            end
            ST_STEER: begin
                n_state = (r_cnt == '0) ? ST_OUT : ST_UV_ABS;
            end
            ST_CO_X: begin
                m_a = $signed(25'(r_cnt));
                m_b = $signed(25'(r_self_x));
                n_state = ST_CO_Y;
            end
            ST_CO_Y: begin
                m_a = $signed(25'(r_cnt));
                m_b = $signed(25'(r_self_y));
                n_state = ST_CO_SET;
            end
            ST_CO_SET: n_state = ST_UV_ABS;
            ST_UV_ABS: n_state = ST_UV_SHIFT;
            ST_UV_SHIFT: begin
                if (r_ma == '0 && r_mb == '0) begin
                    n_state = ST_UV_END;
                end else if (|(r_ma[VW-1:MAG_W] | r_mb[VW-1:MAG_W])) begin
                    n_state = ST_UV_SHIFT;
                end else begin
                    n_state = ST_UV_SQA;
                end
            end
            ST_UV_SQA: begin
                m_a = $signed({1'b0, r_ma[MAG_W-1:0]});
                m_b = $signed({1'b0, r_ma[MAG_W-1:0]});
                n_state = ST_UV_SQB;
            end
            ST_UV_SQB: begin
                m_a = $signed({1'b0, r_mb[MAG_W-1:0]});
                m_b = $signed({1'b0, r_mb[MAG_W-1:0]});
                n_state = ST_UV_SQC;
            end
            ST_UV_SQC: n_state = ST_UV_ROOT;
            ST_UV_ROOT: begin
                sq_start = !r_sub;
                if (sq_done) begin
                    n_state = ST_UV_DIVA;
                end
            end
            ST_UV_DIVA: begin
                div_start = !r_sub;
                div_num   = {r_ma[MAG_W-1:0], {UNIT_SHIFT{1'b0}}};
                div_den   = r_len;
                if (div_done) begin
                    n_state = ST_UV_DIVB;
                end
            end
            ST_UV_DIVB: begin
                div_start = !r_sub;
                div_num   = {r_mb[MAG_W-1:0], {UNIT_SHIFT{1'b0}}};
                div_den   = r_len;
                if (div_done) begin
                    n_state = ST_UV_END;
                end
            end
            ST_UV_END: begin
                case (r_vec)
                    2'd0:    n_state = ST_CO_X;
                    2'd1:    n_state = ST_UV_ABS;
                    2'd2:    n_state = ST_WT_MUL;
                    default: n_state = ST_SC_X;
                endcase
            end
            ST_WT_MUL: begin
                case (r_k)
                    3'd0:    begin m_a = 25'(r_ga); m_b = 25'(r_ax); end
                    3'd1:    begin m_a = 25'(r_ga); m_b = 25'(r_ay); end
                    3'd2:    begin m_a = 25'(r_gc); m_b = 25'(r_cx); end
                    3'd3:    begin m_a = 25'(r_gc); m_b = 25'(r_cy); end
                    3'd4:    begin m_a = 25'(r_gs); m_b = 25'(r_sx); end
                    default: begin m_a = 25'(r_gs); m_b = 25'(r_sy); end
                endcase
                n_state = ST_WT_ADD;
            end
            ST_WT_ADD: begin
                n_state = (r_k == 3'd5) ? ST_UV_ABS : ST_WT_MUL;
            end
            ST_SC_X: begin
                m_a = $signed(25'(abs_ua));
                m_b = $signed(25'(r_target));
                n_state = ST_SC_Y;
            end
            ST_SC_Y: begin
                m_a = $signed(25'(abs_ub));
                m_b = $signed(25'(r_target));
                n_state = ST_SC_SET;
            end
            ST_SC_SET: n_state = ST_OUT;
            ST_MV_X: begin
                div_start = !r_sub;
                div_num   = DIV_NW'(mv_mag);
                div_den   = DIV_DW'(mv_span);
                if (div_done) begin
                    n_state = ST_MV_Y;
                end
            end
            ST_MV_Y: begin
                div_start = !r_sub;
                div_num   = DIV_NW'(mv_mag);
                div_den   = DIV_DW'(mv_span);
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd800;
            r_height <= 12'd600;
            r_view   <= 12'd100;
            r_target <= 15'd1280;
            r_gs     <= 16'sd256;
            r_ga     <= 16'sd256;
            r_gc     <= 16'sd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIELD_WIDTH:  r_width  <= i_cfg_data[11:0];
                CFG_FIELD_HEIGHT: r_height <= i_cfg_data[11:0];
                CFG_VIEW_RANGE:   r_view   <= i_cfg_data[11:0];
                CFG_TARGET_SPEED: r_target <= i_cfg_data[14:0];
                CFG_SEP_GAIN:     r_gs     <= $signed(i_cfg_data);
                CFG_ALIGN_GAIN:   r_ga     <= $signed(i_cfg_data);
                CFG_COH_GAIN:     r_gc     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // own boid, sums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_x    <= '0;
            r_self_y    <= '0;
            r_self_vx   <= '0;
            r_self_vy   <= '0;
            r_sum_vel_x <= '0;
            r_sum_vel_y <= '0;
            r_sum_pos_x <= '0;
            r_sum_pos_y <= '0;
            r_sum_off_x <= '0;
            r_sum_off_y <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_sub       <= 1'b0;
            r_clr       <= 1'b0;
        end else begin
            if (div_start || sq_start) begin
                r_sub <= 1'b1;
            end else if (div_done || sq_done) begin
                r_sub <= 1'b0;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in_item.func == FN_LOAD) begin
                        r_self_x    <= i_in_item.pos_x;
                        r_self_y    <= i_in_item.pos_y;
                        r_self_vx   <= i_in_item.vel_x;
                        r_self_vy   <= i_in_item.vel_y;
                        r_sum_vel_x <= '0;
                        r_sum_vel_y <= '0;
                        r_sum_pos_x <= '0;
                        r_sum_pos_y <= '0;
                        r_sum_off_x <= '0;
                        r_sum_off_y <= '0;
                        r_cnt       <= '0;
                    end
                    r_clr <= (i_in_item.func == FN_NEIGHBOR);
                end
                ST_NB_ACC: begin
                    if (hit) begin
                        r_sum_vel_x <= r_sum_vel_x + SVW'(r_nvx);
                        r_sum_vel_y <= r_sum_vel_y + SVW'(r_nvy);
                        r_sum_pos_x <= r_sum_pos_x + SPW'(r_px);
                        r_sum_pos_y <= r_sum_pos_y + SPW'(r_py);
                        r_sum_off_x <= r_sum_off_x + SOW'(r_dx);
                        r_sum_off_y <= r_sum_off_y + SOW'(r_dy);
                        r_cnt       <= r_cnt + 1'b1;
                    end
                end
                ST_SC_Y: begin
                    r_self_vx <= r_ua < 0 ? -$signed(rnd[29:14]) : $signed(rnd[29:14]);
                end
                ST_SC_SET: begin
                    r_self_vy <= r_ub < 0 ? -$signed(rnd[29:14]) : $signed(rnd[29:14]);
                end
                ST_MV_X: begin
                    if (div_done) begin
                        r_self_x <= mv_fold[19:0];
                    end
                end
                ST_MV_Y: begin
                    if (div_done) begin
                        r_self_y <= mv_fold[19:0];
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        if (r_clr) begin
                            r_sum_vel_x <= '0;
                            r_sum_vel_y <= '0;
                            r_sum_pos_x <= '0;
                            r_sum_pos_y <= '0;
                            r_sum_off_x <= '0;
                            r_sum_off_y <= '0;
                            r_cnt       <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        case (r_state)
            ST_IDLE: begin
                r_px   <= i_in_item.pos_x;
                r_py   <= i_in_item.pos_y;
                r_nvx  <= i_in_item.vel_x;
                r_nvy  <= i_in_item.vel_y;
                r_last <= i_in_item.last;
                r_dx   <= $signed({1'b0, i_in_item.pos_x}) - $signed({1'b0, r_self_x});
                r_dy   <= $signed({1'b0, i_in_item.pos_y}) - $signed({1'b0, r_self_y});
            end
            ST_NB_DY: r_acc <= SQ_W'(r_prod);
            ST_NB_LIM: r_acc <= r_acc + SQ_W'(r_prod);
            ST_STEER: begin
                r_va  <= VW'(r_sum_vel_x);
                r_vb  <= VW'(r_sum_vel_y);
                r_vec <= 2'd0;
            end
            ST_CO_Y: r_va <= $signed(VW'(r_sum_pos_x)) - VW'(r_prod);
            ST_CO_SET: begin
                r_vb  <= $signed(VW'(r_sum_pos_y)) - VW'(r_prod);
                r_vec <= 2'd1;
            end
            ST_UV_ABS: begin
                r_ma <= r_va < 0 ? VW'(-r_va) : VW'(r_va);
                r_mb <= r_vb < 0 ? VW'(-r_vb) : VW'(r_vb);
                r_na <= r_va < 0;
                r_nb <= r_vb < 0;
                r_ua <= '0;
                r_ub <= '0;
            end
            ST_UV_SHIFT: begin
                if (|(r_ma[VW-1:MAG_W] | r_mb[VW-1:MAG_W])) begin
                    r_ma <= r_ma >> 1;
                    r_mb <= r_mb >> 1;
                end
            end
            ST_UV_SQB: r_acc <= SQ_W'(r_prod);
            ST_UV_SQC: r_acc <= r_acc + SQ_W'(r_prod);
            ST_UV_ROOT: begin
                if (sq_done) begin
                    r_len <= sq_root;
                end
            end
            ST_UV_DIVA: begin
                if (div_done) begin
                    r_ua <= r_na ? -$signed(q16) : $signed(q16);
                end
            end
            ST_UV_DIVB: begin
                if (div_done) begin
                    r_ub <= r_nb ? -$signed(q16) : $signed(q16);
                end
            end
            ST_UV_END: begin
                case (r_vec)
                    2'd0: begin
                        r_ax <= r_ua;
                        r_ay <= r_ub;
                    end
                    2'd1: begin
                        // separation points away from the mean offset
                        r_cx  <= r_ua;
                        r_cy  <= r_ub;
                        r_va  <= -VW'(r_sum_off_x);
                        r_vb  <= -VW'(r_sum_off_y);
                        r_vec <= 2'd2;
                    end
                    2'd2: begin
                        r_sx <= r_ua;
                        r_sy <= r_ub;
                        r_va <= VW'(r_self_vx) <<< UNIT_SHIFT;
                        r_vb <= VW'(r_self_vy) <<< UNIT_SHIFT;
                        r_k  <= 3'd0;
                    end
                    default: ;
                endcase
            end
            ST_WT_ADD: begin
                if (r_k[0]) begin
                    r_vb <= r_vb + VW'(r_prod);
                end else begin
                    r_va <= r_va + VW'(r_prod);
                end
                r_k <= r_k + 1'b1;
                if (r_k == 3'd5) begin
                    r_vec <= 2'd3;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out.new_x      <= r_self_x;
                    r_out.new_y      <= r_self_y;
                    r_out.new_vx     <= r_self_vx;
                    r_out.new_vy     <= r_self_vy;
                    r_out.seen_count <= 9'(r_cnt);
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/boid_div.sv]
// boid_div: restoring divider, one quotient bit per cycle
// depends on boid_pkg for its widths
`timescale 1ns / 1ps

module boid_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [boid_pkg::DIV_NW-1:0]  i_num,
    input  logic [boid_pkg::DIV_DW-1:0]  i_den,
    output logic                         o_done,
    output logic [boid_pkg::DIV_NW-1:0]  o_quot,
    output logic [boid_pkg::DIV_DW-1:0]  o_rem
);
    import boid_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_num[DIV_NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_NW-2:0], 1'b0};
            r_quot <= {r_quot[DIV_NW-2:0], fits};
            r_rem  <= fits ? DIV_DW'(trial - {1'b0, r_den}) : DIV_DW'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[rtl/boid_sqrt.sv]
// boid_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on boid_pkg for its widths
`timescale 1ns / 1ps

module boid_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [boid_pkg::SQ_W-1:0]  i_op,
    output logic                       o_done,
    output logic [boid_pkg::SQ_RW-1:0] o_root
);
    import boid_pkg::*;

    localparam int CNT_W = $clog2(SQ_RW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_op;
    logic [SQ_W-1:0]  r_res;
    logic [SQ_W-1:0]  r_one;
    logic [SQ_W-1:0]  trial;

    assign trial = r_res + r_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SQ_RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_res <= '0;
            r_one <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (r_op >= trial) begin
                r_op  <= r_op - trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[SQ_RW-1:0];

endmodule

[dv/testbench.sv]
// testbench: self-checking bench for boid_flocking_update, predicts each result
// in its own flocking model and compares field by field; depends on boid_pkg
`timescale 1ns / 1ps

module testbench;
    import boid_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    localparam int NB_MAX = 256;

    boid_flocking_update uut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    longint unsigned m_width, m_height, m_view, m_speed;
    longint m_gsep, m_galign, m_gcoh;
    longint unsigned m_x, m_y;
    longint m_vx, m_vy;
    longint m_svel[2], m_spos[2], m_soff[2];
    int unsigned m_count;

    t_out_item expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int hold_cycles = 0;
    bit stall_random = 1'b1;

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    task automatic unit_of(input longint a, input longint b, output longint ua,
                           output longint ub);
        longint unsigned ma, mb, big, len;
        ma = absval(a);
        mb = absval(b);
        big = ma > mb ? ma : mb;
        if (big == 0) begin
            ua = 0;
            ub = 0;
            return;
        end
        while (big >= (64'd1 << 24)) begin
            big >>= 1;
            ma >>= 1;
            mb >>= 1;
        end
        len = isqrt(ma * ma + mb * mb);
        ua = longint'(ma * 16384 / len);
        ub = longint'(mb * 16384 / len);
        if (a < 0) ua = -ua;
        if (b < 0) ub = -ub;
    endtask

    function automatic longint speed_of(longint u);
        longint r;
        r = longint'((absval(u) * m_speed + 8192) >> 14);
        return u < 0 ? -r : r;
    endfunction

    function automatic longint unsigned wrap_coord(longint v, longint unsigned sz);
        longint span, r;
        span = sz != 0 ? longint'(sz << 8) : (64'sd1 << 20);
        r = v % span;
        if (r < 0) r += span;
        return longint'(r);
    endfunction

    task automatic clear_sums();
        m_svel = '{0, 0};
        m_spos = '{0, 0};
        m_soff = '{0, 0};
        m_count = 0;
    endtask

    task automatic steer_velocity();
        longint ax, ay, cx, cy, sx, sy, tx, ty, nx, ny, c;
        if (m_count == 0) return;
        c = m_count;
        unit_of(m_svel[0], m_svel[1], ax, ay);
        unit_of(m_spos[0] - c * longint'(m_x), m_spos[1] - c * longint'(m_y), cx, cy);
        unit_of(-m_soff[0], -m_soff[1], sx, sy);
        tx = m_vx * 16384 + m_galign * ax + m_gcoh * cx + m_gsep * sx;
        ty = m_vy * 16384 + m_galign * ay + m_gcoh * cy + m_gsep * sy;
        unit_of(tx, ty, nx, ny);
        m_vx = speed_of(nx);
        m_vy = speed_of(ny);
    endtask

    task automatic push_result();
        t_out_item r;
        r.new_x = m_x[19:0];
        r.new_y = m_y[19:0];
        r.new_vx = m_vx[15:0];
        r.new_vy = m_vy[15:0];
        r.seen_count = m_count[8:0];
        expected_q.push_back(r);
    endtask

    task automatic predict_item(input t_in_item it);
        longint dx, dy;
        longint unsigned dsq, lim;
        case (it.func)
            FN_LOAD: begin
                m_x = it.pos_x;
                m_y = it.pos_y;
                m_vx = it.vel_x;
                m_vy = it.vel_y;
                clear_sums();
            end
            FN_NEIGHBOR: begin
                dx = longint'(it.pos_x) - longint'(m_x);
                dy = longint'(it.pos_y) - longint'(m_y);
                dsq = dx * dx + dy * dy;
                lim = m_view << 8;
                if (dsq > 0 && dsq < lim * lim && m_count < NB_MAX) begin
                    m_svel[0] += it.vel_x;
                    m_svel[1] += it.vel_y;
                    m_spos[0] += it.pos_x;
                    m_spos[1] += it.pos_y;
                    m_soff[0] += dx;
                    m_soff[1] += dy;
                    m_count++;
                end
                if (it.last) begin
                    steer_velocity();
                    push_result();
                    clear_sums();
                end
            end
            FN_MOVE: begin
                m_x = wrap_coord(longint'(m_x) + m_vx, m_width);
                m_y = wrap_coord(longint'(m_y) + m_vy, m_height);
                push_result();
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        errors++;
        $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // sends one request, bursty gaps when enabled
    bit gaps_on = 1'b1;
    int burst_left = 0;

    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        i_cfg_index <= idx;
        i_cfg_data <= value[15:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FIELD_WIDTH:  m_width = value & 12'hfff;
            CFG_FIELD_HEIGHT: m_height = value & 12'hfff;
            CFG_VIEW_RANGE:   m_view = value & 12'hfff;
            CFG_TARGET_SPEED: m_speed = value & 15'h7fff;
            CFG_SEP_GAIN:     m_gsep = longint'(signed'(value[15:0]));
            CFG_ALIGN_GAIN:   m_galign = longint'(signed'(value[15:0]));
            CFG_COH_GAIN:     m_gcoh = longint'(signed'(value[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_all(input longint w, input longint h, input longint v,
                           input longint s, input longint gs, input longint ga,
                           input longint gc);
        wait_drained();
        write_reg(CFG_FIELD_WIDTH, w);
        write_reg(CFG_FIELD_HEIGHT, h);
        write_reg(CFG_VIEW_RANGE, v);
        write_reg(CFG_TARGET_SPEED, s);
        write_reg(CFG_SEP_GAIN, gs);
        write_reg(CFG_ALIGN_GAIN, ga);
        write_reg(CFG_COH_GAIN, gc);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_item(input logic [1:0] f, input longint px,
                                           input longint py, input longint vx,
                                           input longint vy, input bit l);
        t_in_item it;
        it.func = f;
        it.pos_x = px[19:0];
        it.pos_y = py[19:0];
        it.vel_x = vx[15:0];
        it.vel_y = vy[15:0];
        it.last = l;
        return it;
    endfunction

    // neighbor near the own boid, offset scaled to the view radius
    function automatic t_in_item near_item(input bit l);
        longint r, px, py;
        r = longint'(m_view) * 256;
        px = longint'(m_x) + $signed($urandom_range(0, 2 * r)) - r;
        py = longint'(m_y) + $signed($urandom_range(0, 2 * r)) - r;
        if (px < 0) px = 0;
        if (py < 0) py = 0;
        return make_item(FN_NEIGHBOR, px, py, $urandom, $urandom, l);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_q.pop_front();
                if (o_out_item.new_x !== want.new_x)
                    report_mismatch("new_x", o_out_item.new_x, want.new_x);
                if (o_out_item.new_y !== want.new_y)
                    report_mismatch("new_y", o_out_item.new_y, want.new_y);
                if (o_out_item.new_vx !== want.new_vx)
                    report_mismatch("new_vx", o_out_item.new_vx, want.new_vx);
                if (o_out_item.new_vy !== want.new_vy)
                    report_mismatch("new_vy", o_out_item.new_vy, want.new_vy);
                if (o_out_item.seen_count !== want.seen_count)
                    report_mismatch("seen_count", o_out_item.seen_count, want.seen_count);
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 23;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (!stall_random) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= (stall_phase < 14) ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    task automatic test_directed();
        set_all(800, 600, 100, 1280, 256, 256, 256);
        send_item(make_item(FN_LOAD, 400 * 256, 300 * 256, 256, 0, 1));
        // nothing in range keeps the velocity
        send_item(make_item(FN_NEIGHBOR, 400 * 256, 300 * 256, 5, 5, 1));
        send_item(make_item(FN_NEIGHBOR, 410 * 256, 305 * 256, -300, 200, 0));
        send_item(make_item(FN_NEIGHBOR, 395 * 256, 290 * 256, 32767, -32768, 0));
        send_item(make_item(FN_NEIGHBOR, 1048575, 1048575, 0, 0, 0));
        send_item(make_item(FN_NEIGHBOR, 402 * 256, 299 * 256, 100, 100, 1));
        send_item(make_item(FN_MOVE, 0, 0, 0, 0, 1));
        send_item(make_item(2'd3, 1048575, 1048575, -1, -1, 1));
        // wrap both ways at the edges
        send_item(make_item(FN_LOAD, 0, 0, -32768, -32768, 0));
        send_item(make_item(FN_MOVE, 0, 0, 0, 0, 0));
        send_item(make_item(FN_LOAD, 799 * 256 + 255, 599 * 256 + 255, 32767, 32767, 0));
        send_item(make_item(FN_MOVE, 0, 0, 0, 0, 0));
        // zero weights and a resting boid giving a zero steering sum
        set_all(0, 4095, 4095, 32767, 0, 0, 0);
        send_item(make_item(FN_LOAD, 1048575, 0, 0, 0, 0));
        send_item(make_item(FN_NEIGHBOR, 1048575 - 256, 256, 50, -50, 1));
        send_item(make_item(FN_MOVE, 0, 0, 0, 0, 0));
        set_all(1, 1, 1, 1, -32768, 32767, -32768);
        send_item(make_item(FN_LOAD, 512, 512, 300, -300, 0));
        send_item(make_item(FN_NEIGHBOR, 600, 400, -1, 1, 1));
        send_item(make_item(FN_MOVE, 0, 0, 0, 0, 0));
    endtask

    task automatic test_full_count();
        // more in-range neighbors than the block counts
        set_all(4095, 4095, 4095, 1280, 256, 256, 256);
        send_item(make_item(FN_LOAD, 2048 * 256, 2048 * 256, 100, 50, 0));
        for (int k = 0; k < NB_MAX + 6; k++)
            send_item(make_item(FN_NEIGHBOR, 2048 * 256 + 1 + k * 16,
                                2048 * 256 - k * 8, $urandom, $urandom,
                                k == NB_MAX + 5));
    endtask

    task automatic test_backpressure();
        wait_drained();
        gaps_on = 1'b0;
        hold_cycles = 2000;
        send_item(make_item(FN_LOAD, $urandom, $urandom, $urandom, $urandom, 0));
        for (int k = 0; k < 12; k++) send_item(make_item(FN_MOVE, 0, 0, 0, 0, 0));
        gaps_on = 1'b1;
    endtask

    task automatic test_random(input int n_items);
        int k;
        int r;
        k = 0;
        while (k < n_items) begin
            if (k % 300 == 0) begin
                set_all($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(1, 400), $urandom_range(1, 32767),
                        $urandom, $urandom, $urandom);
                stall_random = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                // well-formed flock: load, a few neighbors, optional moves
                send_item(make_item(FN_LOAD, $urandom, $urandom, $urandom, $urandom,
                                    1'($urandom_range(0, 1))));
                k++;
                for (int j = $urandom_range(0, 8); j >= 0; j--) begin
                    send_item(near_item(j == 0));
                    k++;
                end
                repeat ($urandom_range(0, 2)) begin
                    send_item(make_item(FN_MOVE, $urandom, $urandom, $urandom,
                                        $urandom, 1'($urandom_range(0, 1))));
                    k++;
                end
            end else begin
                send_item(make_item(2'($urandom_range(0, 3)), $urandom, $urandom,
                                    $urandom, $urandom, 1'($urandom_range(0, 1))));
                k++;
            end
        end
    endtask

    initial begin
        m_width = 800; m_height = 600; m_view = 100; m_speed = 1280;
        m_gsep = 256; m_galign = 256; m_gcoh = 256;
        m_x = 0; m_y = 0; m_vx = 0; m_vy = 0;
        clear_sums();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_count();
        test_backpressure();
        test_random(1500);
        wait_drained();
        $display("covered %0d requests and %0d results across directed, full count,",
                 items_sent, results_seen);
        $display("long receiver hold-off and random register settings");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
rtl/boid_pkg.sv
rtl/boid_div.sv
rtl/boid_sqrt.sv
rtl/boid_flocking_update.sv
dv/testbench.sv
